// ----- rtl/pna_pkg.sv -----
// ----------------------------------------------------------------------------
// pna_pkg
// shared widths, constants, types and helpers for the prime neighbourhood
// average block
// ----------------------------------------------------------------------------
`default_nettype none

package pna_pkg;

    // width of the value field
    localparam int VALUE_BITS      = 16;
    // ceiling on the number of primes gathered on each side
    localparam int MAX_PRIME_COUNT = 64;

    // configuration register and bus
    localparam int CFG_BITS   = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // candidates run past the top of the value range on the upward search
    localparam int CAND_BITS = VALUE_BITS + 1;
    localparam int AVG_BITS  = VALUE_BITS + 1;
    localparam int CNT_BITS  = $clog2(MAX_PRIME_COUNT + 1);
    localparam int DEN_BITS  = $clog2(2 * MAX_PRIME_COUNT + 2);
    localparam int SUM_BITS  = CAND_BITS + DEN_BITS;

    // trial divisors stay a little above the square root of a candidate
    localparam int DVS_TRIAL = CAND_BITS / 2 + 2;
    localparam int DVS_BITS  = (DVS_TRIAL > DEN_BITS) ? DVS_TRIAL : DEN_BITS;
    localparam int SQ_BITS   = 2 * DVS_BITS;
    localparam int ITER_BITS = $clog2(SUM_BITS + 1);
    localparam int CLAMP_W   = (CFG_BITS > CNT_BITS) ? CFG_BITS : CNT_BITS;

    // trial division constants
    localparam logic [DVS_BITS-1:0] DIV_TWO   = DVS_BITS'(2);
    localparam logic [DVS_BITS-1:0] DIV_THREE = DVS_BITS'(3);
    localparam logic [DVS_BITS-1:0] DIV_FIVE  = DVS_BITS'(5);
    localparam logic [DVS_BITS-1:0] STEP_LO   = DVS_BITS'(2);
    localparam logic [DVS_BITS-1:0] STEP_HI   = DVS_BITS'(4);

    // register index
    localparam logic [APB_ADDR_W-3:0] REG_PRIME_COUNT = '0;

    // serial divider request and response
    typedef struct packed {
        logic                start;
        logic                full;      // full width division, else candidate modulo
        logic [SUM_BITS-1:0] dividend;  // left aligned
        logic [DVS_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SUM_BITS-1:0] quotient;
        logic [DVS_BITS-1:0] remainder;
    } t_div_rsp;

    // zero reads as one, large values saturate
    function automatic logic [CNT_BITS-1:0] eff_count(input logic [CFG_BITS-1:0] raw);
        logic [CLAMP_W-1:0] w;
        logic [CNT_BITS-1:0] res;
        w = CLAMP_W'(raw);
        if (w == '0) begin
            res = CNT_BITS'(1);
        end else if (w > CLAMP_W'(MAX_PRIME_COUNT)) begin
            res = CNT_BITS'(MAX_PRIME_COUNT);
        end else begin
            res = CNT_BITS'(w);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pna_if.sv -----
// ----------------------------------------------------------------------------
// pna_if
// valid/ready channels for the value and the result items
// ----------------------------------------------------------------------------
`default_nettype none

interface pna_in_if;
    import pna_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] center_value;

    modport source (output valid, output center_value, input ready);
    modport sink   (input valid, input center_value, output ready);
endinterface

interface pna_out_if;
    import pna_pkg::*;

    logic                valid;
    logic                ready;
    logic [AVG_BITS-1:0] average;
    logic                short_below;
    logic                center_is_prime;

    modport source (output valid, output average, output short_below,
                    output center_is_prime, input ready);
    modport sink   (input valid, input average, input short_below,
                    input center_is_prime, output ready);
endinterface

`default_nettype wire

// ----- rtl/pna_serdiv.sv -----
// ----------------------------------------------------------------------------
// pna_serdiv
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pna_serdiv (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pna_pkg::t_div_req i_req,
    output pna_pkg::t_div_rsp      o_rsp
);
    import pna_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [ITER_BITS-1:0] r_iter;
    logic [SUM_BITS-1:0]  r_shift;
    logic [DVS_BITS-1:0]  r_rem;
    logic [DVS_BITS-1:0]  r_dvs;

    logic [DVS_BITS:0]    trial;
    logic                 fits;
    logic [DVS_BITS-1:0]  n_rem;

    // partial remainder with the next dividend bit brought down
    always_comb begin
        trial = {r_rem, r_shift[SUM_BITS-1]};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? DVS_BITS'(trial - {1'b0, r_dvs}) : trial[DVS_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_iter  <= i_req.full ? ITER_BITS'(SUM_BITS) : ITER_BITS'(CAND_BITS);
                r_shift <= i_req.dividend;
                r_rem   <= '0;
                r_dvs   <= i_req.divisor;
            end else if (r_busy) begin
                r_shift <= {r_shift[SUM_BITS-2:0], fits};
                r_rem   <= n_rem;
                r_iter  <= r_iter - ITER_BITS'(1);
                if (r_iter == ITER_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_shift;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// ----- rtl/prime_neighbourhood_average.sv -----
// ----------------------------------------------------------------------------
// prime_neighbourhood_average
// average of the primes around a value, found by serial trial division
// ----------------------------------------------------------------------------
// For each value item the block gathers prime_count primes strictly below and
// strictly above it (and the value itself when prime), and returns the sum
// truncated-divided by 2*prime_count, plus one when the value is prime. If
// fewer primes lie below, the search stops at 2, short_below is raised and
// the denominator keeps its full size. prime_count zero acts as one; values
// above MAX_PRIME_COUNT saturate. One item is in work at a time; a new item
// can be taken while the previous result still waits at the output. Every
// trial division and the final average go through one shared bit-serial
// divider; the divisor square comes from a multiplier. The time an item
// takes depends on the data: how many candidates are tested and how many
// divisors up to their square roots each prime needs. prime_count lives at
// byte address 0 of the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_neighbourhood_average (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    pna_in_if.sink                              i_in,
    pna_out_if.source                           o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pna_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pna_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pna_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import pna_pkg::*;

    // search phase: what the primality result is used for
    typedef enum logic [1:0] {
        PH_DOWN,
        PH_CENTRE,
        PH_UP
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOWN_STEP,
        S_UP_STEP,
        S_T_START,
        S_T_SQ,
        S_T_CMP,
        S_T_MOD,
        S_T_WAIT,
        S_T_RET,
        S_AVG,
        S_AVG_WAIT,
        S_OUT
    } t_state;

    // configuration
    logic [CFG_BITS-1:0]  r_prime_count;

    // sequencer
    t_state               r_state;
    t_phase               r_phase;
    logic [CAND_BITS-1:0] r_val;
    logic [CAND_BITS-1:0] r_cand;
    logic [CAND_BITS-1:0] r_test;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [CNT_BITS-1:0]  r_left;
    logic [SUM_BITS-1:0]  r_sum;
    logic [DEN_BITS-1:0]  r_denom;
    logic                 r_short;
    logic                 r_cprime;
    logic                 r_is_prime;
    logic [DVS_BITS-1:0]  r_d;
    logic                 r_hi;      // testing the 6k+1 member of a pair
    logic [SQ_BITS-1:0]   r_dsq;
    logic [AVG_BITS-1:0]  r_avg;

    // output register
    logic                 r_out_valid;
    logic [AVG_BITS-1:0]  r_out_avg;
    logic                 r_out_short;
    logic                 r_out_cprime;

    t_div_req             div_req;
    t_div_rsp             div_rsp;

    logic                 cfg_wr;
    logic                 in_take;
    logic                 out_free;
    logic [CNT_BITS-1:0]  cnt_in;

    // ---- configuration port: zero wait states, one register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_count <= CFG_BITS'(1);
        end else if (cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_PRIME_COUNT)) begin
            r_prime_count <= pwdata[CFG_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_PRIME_COUNT) begin
            prdata = APB_DATA_W'(r_prime_count);
        end
    end

    // ---- shared serial divider: trial modulo and the final average
    always_comb begin
        div_req          = '0;
        div_req.start    = (r_state == S_T_MOD) || (r_state == S_AVG);
        div_req.full     = (r_state == S_AVG);
        if (r_state == S_AVG) begin
            div_req.dividend = r_sum;
            div_req.divisor  = DVS_BITS'(r_denom);
        end else begin
            div_req.dividend = {r_test, {(SUM_BITS - CAND_BITS){1'b0}}};
            div_req.divisor  = r_d;
        end
    end

    pna_serdiv u_serdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---- handshakes
    assign i_in.ready = (r_state == S_IDLE);
    assign in_take    = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign cnt_in     = eff_count(r_prime_count);

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in S_OUT the hand-over below sets the valid bit itself
            if (o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_val   <= CAND_BITS'(i_in.center_value);
                        r_cand  <= CAND_BITS'(i_in.center_value);
                        r_cnt   <= cnt_in;
                        r_left  <= cnt_in;
                        r_sum   <= '0;
                        r_short <= 1'b0;
                        r_denom <= DEN_BITS'({cnt_in, 1'b0});
                        r_phase <= PH_DOWN;
                        r_state <= S_DOWN_STEP;
                    end
                end

                // walk down; stop once 2 has been passed
                S_DOWN_STEP: begin
                    if (r_left == '0 || r_cand <= CAND_BITS'(2)) begin
                        if (r_left != '0) begin
                            r_short <= 1'b1;
                        end
                        r_test  <= r_val;
                        r_phase <= PH_CENTRE;
                        r_state <= S_T_START;
                    end else begin
                        r_cand  <= r_cand - CAND_BITS'(1);
                        r_test  <= r_cand - CAND_BITS'(1);
                        r_state <= S_T_START;
                    end
                end

                S_UP_STEP: begin
                    if (r_left == '0) begin
                        r_state <= S_AVG;
                    end else begin
                        r_cand  <= r_cand + CAND_BITS'(1);
                        r_test  <= r_cand + CAND_BITS'(1);
                        r_state <= S_T_START;
                    end
                end

                // primality test of r_test
                S_T_START: begin
                    if (r_test < CAND_BITS'(2)) begin
                        r_is_prime <= 1'b0;
                        r_state    <= S_T_RET;
                    end else if (r_test < CAND_BITS'(4)) begin
                        r_is_prime <= 1'b1;
                        r_state    <= S_T_RET;
                    end else begin
                        r_d     <= DIV_TWO;
                        r_hi    <= 1'b0;
                        r_state <= S_T_MOD;
                    end
                end

                S_T_SQ: begin
                    r_dsq   <= SQ_BITS'(r_d) * SQ_BITS'(r_d);
                    r_state <= S_T_CMP;
                end

                // divisor past the square root: no factor left
                S_T_CMP: begin
                    if (r_dsq > SQ_BITS'(r_test)) begin
                        r_is_prime <= 1'b1;
                        r_state    <= S_T_RET;
                    end else begin
                        r_state <= S_T_MOD;
                    end
                end

                S_T_MOD: begin
                    r_state <= S_T_WAIT;
                end

                S_T_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder == '0) begin
                            r_is_prime <= 1'b0;
                            r_state    <= S_T_RET;
                        end else if (r_d == DIV_TWO) begin
                            r_d     <= DIV_THREE;
                            r_state <= S_T_MOD;
                        end else if (r_d == DIV_THREE) begin
                            r_d     <= DIV_FIVE;
                            r_state <= S_T_SQ;
                        end else if (!r_hi) begin
                            r_d     <= r_d + STEP_LO;
                            r_hi    <= 1'b1;
                            r_state <= S_T_MOD;
                        end else begin
                            r_d     <= r_d + STEP_HI;
                            r_hi    <= 1'b0;
                            r_state <= S_T_SQ;
                        end
                    end
                end

                // use the test result according to the phase
                S_T_RET: begin
                    case (r_phase)
                        PH_DOWN: begin
                            if (r_is_prime) begin
                                r_sum  <= r_sum + SUM_BITS'(r_cand);
                                r_left <= r_left - CNT_BITS'(1);
                            end
                            r_state <= S_DOWN_STEP;
                        end
                        PH_CENTRE: begin
                            r_cprime <= r_is_prime;
                            if (r_is_prime) begin
                                r_sum   <= r_sum + SUM_BITS'(r_val);
                                r_denom <= r_denom + DEN_BITS'(1);
                            end
                            r_left  <= r_cnt;
                            r_cand  <= r_val;
                            r_phase <= PH_UP;
                            r_state <= S_UP_STEP;
                        end
                        PH_UP: begin
                            if (r_is_prime) begin
                                r_sum  <= r_sum + SUM_BITS'(r_cand);
                                r_left <= r_left - CNT_BITS'(1);
                            end
                            r_state <= S_UP_STEP;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end

                S_AVG: begin
                    r_state <= S_AVG_WAIT;
                end

                S_AVG_WAIT: begin
                    if (div_rsp.done) begin
                        r_avg   <= div_rsp.quotient[AVG_BITS-1:0];
                        r_state <= S_OUT;
                    end
                end

                // hand over once the output register is free
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_avg    <= r_avg;
                        r_out_short  <= r_short;
                        r_out_cprime <= r_cprime;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.average         = r_out_avg;
    assign o_out.short_below     = r_out_short;
    assign o_out.center_is_prime = r_out_cprime;

endmodule

`default_nettype wire

// ----- tb/sv/prime_neighbourhood_average_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_neighbourhood_average_check
// watches the value, result and register traffic of the prime neighbourhood
// average block, predicts every result and compares it field by field
// ----------------------------------------------------------------------------

module prime_neighbourhood_average_check
    import pna_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    pna_in_if                          i_in_ch,
    pna_out_if                         i_out_ch,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output int                         o_outstanding,
    output int                         o_failures
);

    typedef struct packed {
        logic [AVG_BITS-1:0] average;
        logic                short_below;
        logic                center_is_prime;
    } t_outcome;

    typedef struct packed {
        logic [VALUE_BITS-1:0] centre;
        t_outcome              outcome;
    } t_awaited;

    t_awaited            awaited_outcomes[$];
    logic [CFG_BITS-1:0] prime_count;
    int                  mismatches = 0;

    // trial division by 2, 3 and then 6k-1 / 6k+1 up to the square root
    function automatic bit prime_test(input int unsigned v);
        int unsigned d;
        if (v < 2) return 1'b0;
        if (v < 4) return 1'b1;
        if (v % 2 == 0 || v % 3 == 0) return 1'b0;
        for (d = 5; d * d <= v; d += 6) begin
            if (v % d == 0 || v % (d + 2) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_outcome neighbourhood_average(input logic [VALUE_BITS-1:0] centre,
                                                       input logic [CFG_BITS-1:0]   raw_count);
        t_outcome          r;
        int unsigned       per_side;
        int unsigned       left;
        int unsigned       cand;
        int unsigned       denom;
        longint unsigned   total;
        per_side = raw_count;
        if (per_side == 0) per_side = 1;
        if (per_side > MAX_PRIME_COUNT) per_side = MAX_PRIME_COUNT;
        denom = 2 * per_side;
        total = 0;
        r.short_below = 1'b0;
        // downward search gives up once it reaches 2
        left = per_side;
        cand = centre;
        while (left > 0) begin
            if (cand <= 2) begin
                r.short_below = 1'b1;
                break;
            end
            cand--;
            if (prime_test(cand)) begin
                total += cand;
                left--;
            end
        end
        r.center_is_prime = prime_test(centre);
        if (r.center_is_prime) begin
            total += centre;
            denom++;
        end
        left = per_side;
        cand = centre;
        while (left > 0) begin
            cand++;
            if (prime_test(cand)) begin
                total += cand;
                left--;
            end
        end
        r.average = AVG_BITS'(total / denom);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_awaited want;
        t_outcome got;
        if (!i_rst_n) begin
            awaited_outcomes.delete();
            prime_count <= CFG_BITS'(1);
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.average         = i_out_ch.average;
                got.short_below     = i_out_ch.short_below;
                got.center_is_prime = i_out_ch.center_is_prime;
                if (awaited_outcomes.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: average %0d short_below %0b prime %0b",
                                 got.average, got.short_below, got.center_is_prime);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (got !== want.outcome) begin
                        if (mismatches < 10)
                            $display({"mismatch for value %0d: expected average %0d ",
                                      "short_below %0b prime %0b, got %0d %0b %0b"},
                                     want.centre, want.outcome.average,
                                     want.outcome.short_below, want.outcome.center_is_prime,
                                     got.average, got.short_below, got.center_is_prime);
                        mismatches++;
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                want.centre  = i_in_ch.center_value;
                want.outcome = neighbourhood_average(i_in_ch.center_value, prime_count);
                awaited_outcomes.push_back(want);
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[APB_ADDR_W-1:2] == REG_PRIME_COUNT)
                prime_count <= i_pwdata[CFG_BITS-1:0];
        end
        o_outstanding <= awaited_outcomes.size();
        o_failures    <= mismatches;
    end

endmodule

// ----- tb/sv/prime_neighbourhood_average_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_neighbourhood_average_test
// drives values and prime_count settings into the prime neighbourhood
// average block under random idling on both sides, with a checker beside it
// ----------------------------------------------------------------------------

module prime_neighbourhood_average_test;
    import pna_pkg::*;

    // no item for this many cycles means the block has hung
    localparam int QUIET_LIMIT = 400_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    int          outstanding;
    int          failures;
    int          quiet_cycles = 0;
    int unsigned stall_left   = 0;
    bit          idling       = 1'b0;

    pna_in_if  in_ch ();
    pna_out_if out_ch ();

    prime_neighbourhood_average dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    prime_neighbourhood_average_check checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (in_ch),
        .i_out_ch      (out_ch),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_outstanding (outstanding),
        .o_failures    (failures)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side back-pressure: stalls come in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 12);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles that move no item on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // offers one value item and returns at the edge that accepts it; valid stays
    // high so that back-to-back items need no second assignment in one step
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        if (idling && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.center_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // one item is one result, so the block is idle once nothing is awaited;
    // the extra edge lets the checker take in an item accepted just now
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // setup then access phase; junk in the upper data bits must be dropped
    task automatic write_prime_count(input logic [CFG_BITS-1:0] cnt);
        logic [APB_DATA_W-1:0] wdata;
        wdata               = $urandom();
        wdata[CFG_BITS-1:0] = cnt;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({REG_PRIME_COUNT, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // search time grows with both the value and the primes per side, so large
    // counts stay on small values and the full range goes with small counts
    function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned per_side);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        // bottom of the range, where the downward search runs dry
        if (roll < 8) return VALUE_BITS'($urandom_range(0, 5));
        if (per_side > 8) return VALUE_BITS'($urandom_range(0, (roll < 20) ? 511 : 127));
        if (per_side > 3) return (roll < 20) ? VALUE_BITS'($urandom())
                                             : VALUE_BITS'($urandom_range(0, 4095));
        // top of the range, where the upward search leaves the field width
        if (roll < 12) return VALUE_BITS'($urandom_range(65500, 65535));
        return (roll < 35) ? VALUE_BITS'($urandom()) : VALUE_BITS'($urandom_range(0, 4095));
    endfunction

    initial begin
        logic [CFG_BITS-1:0] cnt;
        int unsigned         per_side;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.center_value <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idling = 1'b1;

        // reset count of one: tiny values, the first primes, both ends of the
        // field, the largest 16-bit prime and alternating bit patterns
        send_value(16'd0);
        send_value(16'd1);
        send_value(16'd2);
        send_value(16'd3);
        send_value(16'd4);
        send_value(16'd5);
        send_value(16'hFFFF);
        send_value(16'd65521);
        send_value(16'h5555);
        send_value(16'hAAAA);

        // zero count behaves as one
        drain();
        write_prime_count(CFG_BITS'(0));
        send_value(16'd7);
        send_value(16'd1);

        // all register bits set: saturates to the ceiling
        drain();
        write_prime_count(CFG_BITS'(127));
        send_value(16'd0);
        send_value(16'd2);
        send_value(16'd100);

        // exactly at the ceiling
        drain();
        write_prime_count(CFG_BITS'(MAX_PRIME_COUNT));
        send_value(16'd3);
        send_value(16'd97);

        // top of the field, the upward search runs past 16 bits
        drain();
        write_prime_count(CFG_BITS'(2));
        send_value(16'hFFFF);
        send_value(16'hFFFE);

        // random phases, each under its own count; two stretches run with no
        // idling at all, the last of them closing the run
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0, 3:    cnt = CFG_BITS'($urandom_range(1, 3));
                1:       cnt = CFG_BITS'($urandom_range(0, 127));
                2:       cnt = CFG_BITS'($urandom_range(4, 8));
                4:       cnt = CFG_BITS'($urandom_range(9, 32));
                default: cnt = CFG_BITS'($urandom_range(1, 2));
            endcase
            write_prime_count(cnt);
            idling   = (phase != 3) && (phase != 5);
            per_side = (cnt == 0) ? 1 : (cnt > MAX_PRIME_COUNT) ? MAX_PRIME_COUNT : cnt;
            repeat (17) send_value(pick_value(per_side));
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pna_pkg.sv
rtl/pna_if.sv
rtl/pna_serdiv.sv
rtl/prime_neighbourhood_average.sv
tb/sv/prime_neighbourhood_average_check.sv
tb/sv/prime_neighbourhood_average_test.sv
